// ===== rtl/dpm_pkg.sv =====
package dpm_pkg;
  localparam int PageBytes = 64;
  localparam int VirtPages = 64;
  localparam int PhysFrames = 8;
  localparam int OffW = $clog2(PageBytes);
  localparam int PageW = $clog2(VirtPages);
  localparam int FrameW = (PhysFrames > 1) ? $clog2(PhysFrames) : 1;
  localparam int EntryW = 3 + FrameW;
  localparam int FrameAddrW = FrameW + OffW;
  localparam int BackAddrW = PageW + OffW;

  typedef struct packed {
    logic valid;
    logic dirty;
    logic chance;
    logic [FrameW-1:0] frame;
  } entry_t;

  typedef enum logic [1:0] {
    StHit = 2'd0,
    StFree = 2'd1,
    StClean = 2'd2,
    StDirty = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    SClear, SIdle, SLook, SScanRd, SScanEv, SWbRd, SWbWr,
    SLdRd, SLdWr, SAccess, SAccWait, SOut
  } state_e;
endpackage

// ===== rtl/dpm_ram.sv =====
module dpm_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/demand_paging_mmu_second_chance.sv =====
// One item is in flight at a time, and the next is taken only after the result has left.
// A fault with a free frame loads the page from the backing store byte by byte, each byte
// read and then written. With no free frame, the second-chance scan visits entries over up
// to two passes; a dirty victim adds a byte-by-byte writeback of the page before the load.
// After reset, a sweep clears the page table and backing store before the first item.
module demand_paging_mmu_second_chance
  import dpm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: vaddr[11:0], wdata[19:12], zero fill; tuser: req_type
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: rdata[7:0], status[9:8], victim_page[15:10]
  output logic [15:0] m_axis_tdata
);
  state_e state_q, state_d;
  logic req_wr_q;
  logic [11:0] vaddr_q;
  logic [7:0] wdata_q;
  logic [7:0] rdata_q, rdata_d;
  status_e status_q, status_d;
  logic [PageW-1:0] victim_q, victim_d;
  logic [PageW:0] scan_q, scan_d;     // scan position over two passes
  logic [OffW:0] cnt_q, cnt_d;        // byte counter during copies
  logic [BackAddrW:0] clr_q, clr_d;   // reset clearing sweep
  logic [PhysFrames-1:0] busy_q, busy_d;
  logic [FrameW-1:0] frame_q, frame_d;
  logic [FrameW-1:0] vframe_q, vframe_d;

  logic [PageW-1:0] page;
  logic [OffW-1:0] off;
  assign page = vaddr_q[OffW +: PageW];
  assign off = vaddr_q[OffW-1:0];

  // page table RAM
  logic pt_we;
  logic [PageW-1:0] pt_wa, pt_ra;
  entry_t pt_wd, pt_rd;
  logic [EntryW-1:0] pt_rd_raw;
  assign pt_rd = entry_t'(pt_rd_raw);
  dpm_ram #(.Width(EntryW), .Depth(VirtPages)) u_pt (
    .clk_i, .we_i(pt_we), .waddr_i(pt_wa), .wdata_i(pt_wd),
    .raddr_i(pt_ra), .rdata_o(pt_rd_raw));

  // frame RAM
  logic fr_we;
  logic [FrameAddrW-1:0] fr_wa, fr_ra;
  logic [7:0] fr_wd, fr_rd;
  dpm_ram #(.Width(8), .Depth(PhysFrames*PageBytes)) u_frame (
    .clk_i, .we_i(fr_we), .waddr_i(fr_wa), .wdata_i(fr_wd),
    .raddr_i(fr_ra), .rdata_o(fr_rd));

  // backing RAM
  logic bk_we;
  logic [BackAddrW-1:0] bk_wa, bk_ra;
  logic [7:0] bk_wd, bk_rd;
  dpm_ram #(.Width(8), .Depth(VirtPages*PageBytes)) u_back (
    .clk_i, .we_i(bk_we), .waddr_i(bk_wa), .wdata_i(bk_wd),
    .raddr_i(bk_ra), .rdata_o(bk_rd));

  // lowest free frame
  logic free_any;
  logic [FrameW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int f = PhysFrames - 1; f >= 0; f--) begin
      if (!busy_q[f]) begin
        free_any = 1'b1;
        free_idx = FrameW'(f);
      end
    end
  end

  logic [OffW-1:0] cidx;
  assign cidx = cnt_q[OffW-1:0];

  always_comb begin
    state_d = state_q;
    rdata_d = rdata_q;
    status_d = status_q;
    victim_d = victim_q;
    scan_d = scan_q;
    cnt_d = cnt_q;
    clr_d = clr_q;
    busy_d = busy_q;
    frame_d = frame_q;
    vframe_d = vframe_q;
    pt_we = 1'b0; pt_wa = page; pt_wd = '0; pt_ra = page;
    fr_we = 1'b0; fr_wa = {frame_q, off}; fr_wd = wdata_q; fr_ra = {frame_q, off};
    bk_we = 1'b0; bk_wa = {victim_q, cidx}; bk_wd = fr_rd; bk_ra = {page, cidx};
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      SClear: begin
        pt_we = (clr_q < (BackAddrW+1)'(VirtPages));
        pt_wa = clr_q[PageW-1:0];
        bk_we = 1'b1;
        bk_wa = clr_q[BackAddrW-1:0];
        bk_wd = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == (BackAddrW+1)'(VirtPages*PageBytes - 1)) state_d = SIdle;
      end
      SIdle: begin
        s_axis_tready = 1'b1;
        // The entry is looked up from the incoming item, since vaddr_q is loaded only
        // at the accepting edge.
        pt_ra = s_axis_tdata[OffW +: PageW];
        if (s_axis_tvalid) state_d = SLook;
      end
      SLook: begin
        rdata_d = '0; victim_d = '0; cnt_d = '0; scan_d = '0;
        if (pt_rd.valid) begin
          status_d = StHit;
          frame_d = pt_rd.frame;
          state_d = SAccess;
        end else if (free_any) begin
          status_d = StFree;
          frame_d = free_idx;
          busy_d[free_idx] = 1'b1;
          state_d = SLdRd;
        end else begin
          state_d = SScanRd;
        end
      end
      SScanRd: begin
        pt_ra = scan_q[PageW-1:0];
        state_d = SScanEv;
      end
      SScanEv: begin
        pt_ra = scan_q[PageW-1:0];
        pt_wa = scan_q[PageW-1:0];
        if (pt_rd.valid && pt_rd.chance) begin
          pt_we = 1'b1;
          pt_wd = pt_rd;
          pt_wd.chance = 1'b0;
        end
        if (pt_rd.valid && !pt_rd.chance) begin
          pt_we = 1'b1;
          pt_wd = '0;
          victim_d = scan_q[PageW-1:0];
          vframe_d = pt_rd.frame;
          frame_d = pt_rd.frame;
          status_d = pt_rd.dirty ? StDirty : StClean;
          state_d = pt_rd.dirty ? SWbRd : SLdRd;
        end else if (scan_q == (PageW+1)'(2*VirtPages - 1)) begin
          // no victim: reuse frame 0
          busy_d[0] = 1'b1;
          frame_d = '0; status_d = StClean; victim_d = '0;
          state_d = SLdRd;
        end else begin
          scan_d = scan_q + 1'b1;
          state_d = SScanRd;
        end
      end
      SWbRd: begin
        fr_ra = {vframe_q, cidx};
        state_d = SWbWr;
      end
      SWbWr: begin
        bk_we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (OffW+1)'(PageBytes - 1)) begin
          cnt_d = '0;
          state_d = SLdRd;
        end else state_d = SWbRd;
      end
      SLdRd: begin
        bk_ra = {page, cidx};
        state_d = SLdWr;
      end
      SLdWr: begin
        fr_we = 1'b1;
        fr_wa = {frame_q, cidx};
        fr_wd = bk_rd;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (OffW+1)'(PageBytes - 1)) state_d = SAccess;
        else state_d = SLdRd;
      end
      SAccess: begin
        pt_we = 1'b1;
        pt_wd.valid = 1'b1;
        pt_wd.chance = 1'b1;
        pt_wd.dirty = req_wr_q | (status_q == StHit && pt_rd.dirty);
        pt_wd.frame = frame_q;
        fr_we = req_wr_q;
        state_d = SAccWait;
      end
      SAccWait: begin
        if (!req_wr_q) rdata_d = fr_rd;
        state_d = SOut;
      end
      SOut: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  assign m_axis_tdata = {victim_q, status_q, rdata_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      clr_q <= '0;
      busy_q <= '0;
      scan_q <= '0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      busy_q <= busy_d;
      scan_q <= scan_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && s_axis_tvalid) begin
      req_wr_q <= s_axis_tuser;
      vaddr_q <= s_axis_tdata[11:0];
      wdata_q <= s_axis_tdata[19:12];
    end
    rdata_q <= rdata_d;
    status_q <= status_d;
    victim_q <= victim_d;
    frame_q <= frame_d;
    vframe_q <= vframe_d;
  end

  // The frame that a faulting item ends up in is always marked busy.
  a_busy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SOut && status_q != StHit) |-> busy_q[frame_q])
    else $error("frame of result not marked busy");
  a_rdy_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output open together");
  a_victim0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (status_q == StHit || status_q == StFree)) |-> victim_q == '0)
    else $error("victim set without eviction");
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import dpm_pkg::*;

  typedef struct packed {
    logic        wr_req;
    logic [11:0] vaddr;
    logic [7:0]  wdata;
  } access_t;

  typedef struct packed {
    logic [7:0] rdata;
    status_e    status;
    logic [5:0] victim;
  } outcome_t;

  localparam int LimitCycles = 4_000_000;
  localparam int RandomItems = 1500;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  demand_paging_mmu_second_chance dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow copy of the memory system: page table, frames, backing store and
  // the busy bit of each frame.
  logic       pt_valid  [VirtPages];
  logic       pt_dirty  [VirtPages];
  logic       pt_chance [VirtPages];
  int         pt_frame  [VirtPages];
  logic [7:0] frame_mem [PhysFrames*PageBytes];
  logic [7:0] backing   [VirtPages*PageBytes];
  logic       busy      [PhysFrames];

  access_t  pending_accesses[$];
  outcome_t expected_outcomes[$];

  int  n_errors;
  int  n_accepted;
  int  n_results;
  int  n_faults;
  int  n_writebacks;
  int  cycles;
  int  phase;
  bit  hold_off;
  bit  in_acc;

  // Grab the lowest free frame, or -1 when all are busy.
  function automatic int grab_free_frame();
    for (int f = 0; f < PhysFrames; f++) begin
      if (!busy[f]) begin
        busy[f] = 1'b1;
        return f;
      end
    end
    return -1;
  endfunction

  // Second-chance sweep: up to two passes from entry 0, clearing chance bits
  // on the way, stopping at the first valid page whose bit is already clear.
  function automatic int sweep_for_victim();
    int p;
    for (int i = 0; i < 2 * VirtPages; i++) begin
      p = i % VirtPages;
      if (pt_valid[p]) begin
        if (pt_chance[p]) pt_chance[p] = 1'b0;
        else return p;
      end
    end
    return -1;
  endfunction

  // Apply one access to the shadow state and return what the block must answer.
  function automatic outcome_t mmu_predict(access_t a);
    outcome_t o;
    int page;
    int off;
    int fr;
    int v;
    int vf;
    page = a.vaddr / PageBytes;
    off = a.vaddr % PageBytes;
    o = '{rdata: 8'd0, status: StHit, victim: 6'd0};
    if (!pt_valid[page]) begin
      fr = grab_free_frame();
      if (fr >= 0) begin
        o.status = StFree;
      end else begin
        v = sweep_for_victim();
        if (v >= 0) begin
          vf = pt_frame[v];
          o.victim = v[5:0];
          if (pt_dirty[v]) begin
            for (int b = 0; b < PageBytes; b++)
              backing[v*PageBytes + b] = frame_mem[vf*PageBytes + b];
            o.status = StDirty;
          end else begin
            o.status = StClean;
          end
          busy[vf] = 1'b0;
          pt_valid[v] = 1'b0;
          pt_dirty[v] = 1'b0;
          pt_chance[v] = 1'b0;
          pt_frame[v] = 0;
          fr = grab_free_frame();
        end
        if (fr < 0) begin
          // Cannot happen while every busy frame has an owner page.
          fr = 0;
          busy[0] = 1'b1;
          o.status = StClean;
          o.victim = 6'd0;
        end
      end
      pt_valid[page] = 1'b1;
      pt_dirty[page] = 1'b0;
      pt_frame[page] = fr;
      for (int b = 0; b < PageBytes; b++)
        frame_mem[fr*PageBytes + b] = backing[page*PageBytes + b];
    end
    pt_chance[page] = 1'b1;
    if (a.wr_req) begin
      pt_dirty[page] = 1'b1;
      frame_mem[pt_frame[page]*PageBytes + off] = a.wdata;
    end else begin
      o.rdata = frame_mem[pt_frame[page]*PageBytes + off];
    end
    return o;
  endfunction

  task automatic report(string what, int got, int want);
    $display("ERROR at cycle %0d, result %0d: %s is %0d, expected %0d",
             cycles, n_results, what, got, want);
    n_errors++;
  endtask

  task automatic queue_access(bit wr, int addr, int data);
    access_t a;
    a.wr_req = wr;
    a.vaddr = addr[11:0];
    a.wdata = data[7:0];
    pending_accesses.push_back(a);
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The phase moves with the number of accepted items: no idling, a sparse
  // sender, a stalling receiver, and both sides idling now and then.
  always_comb phase = (n_accepted / 150) % 4;

  // Driver: a new item goes out at the falling edge once the previous one
  // has been taken, so tvalid never drops while an item waits.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else if (!s_axis_tvalid || in_acc) begin
      if (pending_accesses.size() > 0 &&
          !(phase == 1 && $urandom_range(99) < 75) &&
          !(phase == 3 && $urandom_range(99) < 16)) begin
        s_axis_tdata  <= {4'b0, pending_accesses[0].wdata, pending_accesses[0].vaddr};
        s_axis_tuser  <= pending_accesses[0].wr_req;
        s_axis_tvalid <= 1'b1;
        void'(pending_accesses.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver readiness, also changed at the falling edge.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_off &&
                       !(phase == 2 && $urandom_range(99) < 75) &&
                       !(phase == 3 && $urandom_range(99) < 16);
    end
  end

  // Monitor: accepted inputs feed the predictor, accepted results are checked
  // against the oldest expectation.
  always @(posedge clk_i) begin
    access_t  a;
    outcome_t want;
    in_acc <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        a.wr_req = s_axis_tuser;
        a.vaddr = s_axis_tdata[11:0];
        a.wdata = s_axis_tdata[19:12];
        want = mmu_predict(a);
        if (want.status != StHit) n_faults++;
        if (want.status == StDirty) n_writebacks++;
        expected_outcomes.push_back(want);
        n_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (expected_outcomes.size() == 0) begin
          report("unexpected result, tdata", m_axis_tdata, 0);
        end else begin
          want = expected_outcomes.pop_front();
          if (m_axis_tdata[7:0] != want.rdata)
            report("rdata", m_axis_tdata[7:0], want.rdata);
          if (m_axis_tdata[9:8] != want.status)
            report("status", m_axis_tdata[9:8], want.status);
          if (m_axis_tdata[15:10] != want.victim)
            report("victim_page", m_axis_tdata[15:10], want.victim);
        end
      end
    end
  end

  // Watchdog. The clearing pass after reset and the slow fault path are both
  // far inside this bound.
  always @(posedge clk_i) begin
    if (cycles > LimitCycles) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, expected_outcomes.size());
      $display("demand_paging_mmu_second_chance: mismatch");
      $finish;
    end
  end

  // Back-pressure: the receiver holds off for a long stretch while items keep
  // coming, so the block fills and must stall its input.
  initial begin
    hold_off = 1'b0;
    wait (n_accepted >= 40);
    @(negedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(negedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    int pg;
    int r;
    n_errors = 0;
    n_accepted = 0;
    n_results = 0;
    n_faults = 0;
    n_writebacks = 0;
    cycles = 0;
    in_acc = 1'b0;
    for (int p = 0; p < VirtPages; p++) begin
      pt_valid[p] = 1'b0;
      pt_dirty[p] = 1'b0;
      pt_chance[p] = 1'b0;
      pt_frame[p] = 0;
    end
    for (int i = 0; i < PhysFrames*PageBytes; i++) frame_mem[i] = 8'h00;
    for (int i = 0; i < VirtPages*PageBytes; i++) backing[i] = 8'h00;
    for (int f = 0; f < PhysFrames; f++) busy[f] = 1'b0;

    // Directed part: address extremes, both operations, byte extremes, then
    // enough distinct pages to force a dirty writeback and a clean eviction,
    // and a reload of the written-back page.
    queue_access(0, 0, 8'hFF);         // read of a never-written page: zero
    queue_access(1, 0, 8'hFF);         // write makes page 0 dirty
    queue_access(0, 0, 0);             // hit, reads the byte back
    queue_access(1, 4095, 8'h00);      // last page, last offset
    queue_access(0, 4095, 8'hAA);
    queue_access(1, 63, 8'hA5);
    for (int p = 1; p <= 6; p++) queue_access(0, p*PageBytes + p, 0);
    queue_access(0, 7*PageBytes, 0);   // no free frame left: sweep evicts dirty page 0
    queue_access(0, 8*PageBytes, 0);   // next eviction is a clean page
    queue_access(0, 0, 0);             // page 0 returns from the backing store
    queue_access(0, 63, 0);
    queue_access(1, 2047, 8'h5A);
    queue_access(0, 2047, 0);
    queue_access(1, 2048, 8'hC3);
    queue_access(0, 4032, 0);

    // Random part: mostly a small working set so hits and refaults mix, with
    // the rest spread over the whole address space.
    for (int i = 0; i < RandomItems; i++) begin
      r = $urandom_range(99);
      if (r < 80) begin
        pg = $urandom_range(11) + ((i / 300) * 10) % 52;
        queue_access(1'($urandom_range(1)), pg*PageBytes + $urandom_range(PageBytes-1),
                     $urandom_range(255));
      end else begin
        queue_access(1'($urandom_range(1)), $urandom_range(4095), $urandom_range(255));
      end
    end

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_accesses.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_outcomes.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Checked %0d accesses: %0d page faults, %0d of them with a dirty writeback.",
             n_results, n_faults, n_writebacks);
    $display("Sender and receiver idling phases and one long receiver hold-off were run.");
    if (n_errors == 0) begin
      $display("demand_paging_mmu_second_chance: match");
    end else begin
      $display("demand_paging_mmu_second_chance: mismatch");
    end
    $finish;
  end
endmodule
